// ===== rtl/core/slcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_pkg
// Shared constants and controller/datapath interface types of the
// sync/length/checksum deframer.
// ----------------------------------------------------------------------------
package slcd_pkg;

	localparam logic [7:0] SYNC_FIRST   = 8'hAA;
	localparam logic [7:0] SYNC_SECOND  = 8'h55;
	localparam logic [7:0] HEADER_BYTES = 8'd3;

	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 32;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load_len;
		logic load_csum;
		logic load_type;
		logic load_data;
		logic start_emit;
		logic rd;
		logic adv;
	} slcd_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic is_sync1;
		logic is_sync2;
		logic len_ok;
		logic empty;
		logic type_match;
		logic data_done;
		logic data_match;
		logic rd_last;
	} slcd_sts_t;

endpackage

// ===== rtl/core/slcd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_ctrl
// Frame sequencer: sync hunt, header fields, payload collection and
// the emission run of a good frame.
// ----------------------------------------------------------------------------
module slcd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  slcd_pkg::slcd_sts_t sts,
	output slcd_pkg::slcd_cmd_t cmd
);
	import slcd_pkg::*;

	localparam logic [2:0] S_HUNT  = 3'd0;
	localparam logic [2:0] S_SYNC2 = 3'd1;
	localparam logic [2:0] S_LEN   = 3'd2;
	localparam logic [2:0] S_CSUM  = 3'd3;
	localparam logic [2:0] S_TYPE  = 3'd4;
	localparam logic [2:0] S_DATA  = 3'd5;
	localparam logic [2:0] S_READ  = 3'd6;
	localparam logic [2:0] S_SEND  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       acc;

	assign in_ready  = (state_q != S_READ) && (state_q != S_SEND);
	assign out_valid = (state_q == S_SEND);
	assign acc       = in_valid && in_ready;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			S_HUNT: begin
				if (acc && sts.is_sync1) state_nxt = S_SYNC2;
			end
			S_SYNC2: begin
				if (acc) state_nxt = sts.is_sync2 ? S_LEN : S_HUNT;
			end
			S_LEN: begin
				if (acc) begin
					cmd.load_len = sts.len_ok;
					state_nxt    = sts.len_ok ? S_CSUM : S_HUNT;
				end
			end
			S_CSUM: begin
				if (acc) begin
					cmd.load_csum = 1'b1;
					state_nxt     = S_TYPE;
				end
			end
			S_TYPE: begin
				if (acc) begin
					cmd.load_type = 1'b1;
					if (!sts.empty) begin
						state_nxt = S_DATA;
					end else if (sts.type_match) begin
						cmd.start_emit = 1'b1;
						state_nxt      = S_READ;
					end else begin
						state_nxt = S_HUNT;
					end
				end
			end
			S_DATA: begin
				if (acc) begin
					cmd.load_data = 1'b1;
					if (sts.data_done) begin
						// bad checksum drops the frame silently
						cmd.start_emit = sts.data_match;
						state_nxt      = sts.data_match ? S_READ : S_HUNT;
					end
				end
			end
			S_READ: begin
				cmd.rd    = 1'b1;
				state_nxt = S_SEND;
			end
			S_SEND: begin
				if (out_ready) begin
					cmd.adv   = !sts.rd_last;
					state_nxt = sts.rd_last ? S_HUNT : S_READ;
				end
			end
			default: state_nxt = S_HUNT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_HUNT;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ===== rtl/core/slcd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_datapath
// Header registers, running checksum, payload memory and the result
// word of the emission run.
// ----------------------------------------------------------------------------
module slcd_datapath #(
	parameter int MAX_DATA = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [7:0]                      rx_byte,
	input  slcd_pkg::slcd_cmd_t             cmd,
	output slcd_pkg::slcd_sts_t             sts,
	output logic [slcd_pkg::OUT_TDATA_W-1:0] out_word,
	output logic                            out_last
);
	import slcd_pkg::*;

	localparam int CW = $clog2(MAX_DATA + 1);
	localparam int AW = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;

	logic [CW-1:0] count_q;
	logic [CW-1:0] wr_idx_q;
	logic [CW-1:0] rd_idx_q;
	logic [7:0]    csum_q;
	logic [7:0]    sum_q;
	logic [7:0]    type_q;
	logic [7:0]    rd_data_q;
	logic [7:0]    payload_mem_q [MAX_DATA];

	logic [7:0]    len_less;
	logic [7:0]    sum_nxt;
	logic [CW:0]   wr_inc;
	logic [CW:0]   rd_inc;
	logic [CW+4:0] idx_ext;
	logic [CW+4:0] cnt_ext;
	logic [7:0]    data_out;

	assign len_less = rx_byte - HEADER_BYTES;
	assign sum_nxt  = sum_q + rx_byte;
	assign wr_inc   = {1'b0, wr_idx_q} + 1'b1;
	assign rd_inc   = {1'b0, rd_idx_q} + 1'b1;

	assign sts.is_sync1   = (rx_byte == SYNC_FIRST);
	assign sts.is_sync2   = (rx_byte == SYNC_SECOND);
	assign sts.len_ok     = (rx_byte >= HEADER_BYTES) && (len_less <= 8'(MAX_DATA));
	assign sts.empty      = (count_q == '0);
	assign sts.type_match = (rx_byte == csum_q);
	assign sts.data_done  = (wr_inc == {1'b0, count_q});
	assign sts.data_match = (sum_nxt == csum_q);
	assign sts.rd_last    = (count_q == '0) || (rd_inc == {1'b0, count_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			csum_q   <= '0;
			sum_q    <= '0;
			type_q   <= '0;
		end else begin
			if (cmd.load_len) count_q <= len_less[CW-1:0];
			if (cmd.load_csum) csum_q <= rx_byte;
			if (cmd.load_type) begin
				type_q   <= rx_byte;
				sum_q    <= rx_byte;
				wr_idx_q <= '0;
			end
			if (cmd.load_data) begin
				sum_q    <= sum_nxt;
				wr_idx_q <= wr_inc[CW-1:0];
			end
			if (cmd.start_emit) begin
				rd_idx_q <= '0;
			end else if (cmd.adv) begin
				rd_idx_q <= rd_inc[CW-1:0];
			end
		end
	end

	// payload memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.load_data) payload_mem_q[wr_idx_q[AW-1:0]] <= rx_byte;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) rd_data_q <= payload_mem_q[rd_idx_q[AW-1:0]];
	end

	// an empty frame reports a zero data byte
	assign data_out = (count_q == '0) ? 8'd0 : rd_data_q;
	assign idx_ext  = {5'd0, rd_idx_q};
	assign cnt_ext  = {5'd0, count_q};

	assign out_word = {7'd0, cnt_ext[4:0], idx_ext[3:0], data_out, type_q};
	assign out_last = sts.rd_last;

endmodule

// ===== rtl/core/sync_length_checksum_deframer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer_top
// Serial byte deframer: sync pair, length, additive checksum, typed payload.
// ----------------------------------------------------------------------------
// While the block is collecting a frame it holds s_axis_tready high and takes
// each received byte. Once a frame's last byte arrives with a good checksum,
// the block stops taking bytes and plays out one result per payload byte (one
// result with count 0 for an empty frame); each result is first read from the
// payload memory into a register and then presented until the downstream side
// accepts it with tready. A frame of n payload bytes is n + 5 input bytes long.
// Bad frames and bad lengths are dropped with no result and the sync hunt
// restarts.
module sync_length_checksum_deframer_top #(
	parameter int MAX_DATA = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [slcd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // rx_byte[7:0]
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// frame_type[7:0], data_byte[15:8], byte_index[19:16], data_count[24:20], zero
	output logic [slcd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                             m_axis_tlast
);
	import slcd_pkg::*;

	slcd_cmd_t cmd;
	slcd_sts_t sts;

	slcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	slcd_datapath #(
		.MAX_DATA (MAX_DATA)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_byte  (s_axis_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.out_word (m_axis_tdata),
		.out_last (m_axis_tlast)
	);

	// never collecting and emitting at once
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(m_axis_tvalid && s_axis_tready))
		else $error("input and output sides active together");

	// the last result returns the block to the sync hunt
	a_last_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
		else $error("not back to hunting after last result");

	// a non-final result is followed by a memory read cycle
	a_read_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
		(!m_axis_tvalid && !s_axis_tready))
		else $error("missing read cycle between results");

	// emission starts only on an accepted byte
	a_emit_on_byte: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_emit |-> (s_axis_tvalid && s_axis_tready))
		else $error("emission started without an input transaction");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Streams serial bytes into the sync/length/checksum deframer, predicts every
// payload beat from a behavioral copy of the frame parser, and checks the
// output stream beat by beat under random backpressure and input gaps.
// ----------------------------------------------------------------------------
module tb;
	import slcd_pkg::*;

	localparam int DATA_MAX         = 16;
	localparam int CYCLE_LIMIT      = 200000;
	localparam int LONG_HOLD_AT     = 70;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES     = 40;

	typedef struct {
		logic [7:0] octet;
		bit         drain_first;
	} rx_item_t;

	typedef struct {
		logic [7:0] frame_type;
		logic [7:0] data_byte;
		logic [3:0] byte_index;
		logic [4:0] data_count;
		logic       last;
	} payload_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic m_axis_tlast;

	rx_item_t rx_bytes_pending[$];
	payload_beat_t expected_beats[$];

	int offered = 0;
	int accepted = 0;
	int quiet_from = 1 << 30;
	int in_gap = 0;
	int out_gap = 0;
	int hold_left = 0;
	bit long_hold_done = 1'b0;
	int mismatches = 0;
	int cycle_count = 0;

	// parser state mirrored from the block
	int unsigned rx_pos = 0;
	logic [7:0] frame_len = '0;
	logic [7:0] sent_sum = '0;
	logic [7:0] sum_acc = '0;
	logic [7:0] frame_kind = '0;
	logic [7:0] payload_mem[DATA_MAX];

	sync_length_checksum_deframer_top #(
		.MAX_DATA(DATA_MAX)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// advance the frame parser by one received byte, queue any payload beats
	task automatic absorb_rx_byte(input logic [7:0] b);
		bit in_body;
		int unsigned n;
		payload_beat_t beat;
		in_body = 1'b0;
		case (rx_pos)
			0: begin
				if (b == SYNC_FIRST) rx_pos = 1;
			end
			1: begin
				rx_pos = (b == SYNC_SECOND) ? 2 : 0;
			end
			2: begin
				if (b < HEADER_BYTES || int'(b) - int'(HEADER_BYTES) > DATA_MAX) begin
					rx_pos = 0;
				end else begin
					frame_len = b;
					rx_pos = 3;
				end
			end
			3: begin
				sent_sum = b;
				sum_acc = '0;
				rx_pos = 4;
			end
			4: begin
				frame_kind = b;
				sum_acc = b;
				rx_pos = 5;
				in_body = 1'b1;
			end
			default: begin
				if (rx_pos - 5 < DATA_MAX) payload_mem[rx_pos - 5] = b;
				sum_acc = sum_acc + b;
				rx_pos++;
				in_body = 1'b1;
			end
		endcase
		if (in_body && rx_pos >= int'(frame_len) + 2) begin
			rx_pos = 0;
			if (sum_acc == sent_sum) begin
				n = frame_len - HEADER_BYTES;
				if (n == 0) begin
					beat.frame_type = frame_kind;
					beat.data_byte = '0;
					beat.byte_index = '0;
					beat.data_count = '0;
					beat.last = 1'b1;
					expected_beats.push_back(beat);
				end else begin
					for (int unsigned k = 0; k < n; k++) begin
						beat.frame_type = frame_kind;
						beat.data_byte = payload_mem[k];
						beat.byte_index = k[3:0];
						beat.data_count = n[4:0];
						beat.last = (k + 1 == n);
						expected_beats.push_back(beat);
					end
				end
			end
		end
	endtask

	task automatic push_octet(input logic [7:0] b, input bit drain);
		rx_item_t it;
		it.octet = b;
		it.drain_first = drain;
		rx_bytes_pending.push_back(it);
	endtask

	// sync pair, length, checksum, type, payload; a bad frame gets a corrupted checksum
	task automatic queue_frame(input logic [7:0] kind, input logic [7:0] body[$],
			input bit good, input bit drain);
		logic [7:0] cs;
		cs = kind;
		foreach (body[i]) cs = cs + body[i];
		if (!good) cs = cs ^ 8'($urandom_range(1, 255));
		push_octet(SYNC_FIRST, drain);
		push_octet(SYNC_SECOND, 1'b0);
		push_octet(8'(body.size() + 3), 1'b0);
		push_octet(cs, 1'b0);
		push_octet(kind, 1'b0);
		foreach (body[i]) push_octet(body[i], 1'b0);
	endtask

	// sender: holds the current byte until taken, then idles or offers the next
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && accepted < offered) begin
				// still waiting for the transaction
			end else if (in_gap > 0) begin
				in_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (rx_bytes_pending.size() != 0 &&
					!(rx_bytes_pending[0].drain_first && expected_beats.size() != 0)) begin
				s_axis_tdata <= rx_bytes_pending[0].octet;
				s_axis_tvalid <= 1'b1;
				void'(rx_bytes_pending.pop_front());
				offered++;
				if (offered < quiet_from && $urandom_range(0, 5) == 0)
					in_gap = $urandom_range(1, 14);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random stall bursts plus one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (!long_hold_done && accepted >= LONG_HOLD_AT) begin
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (out_gap > 0) begin
				out_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (offered < quiet_from && $urandom_range(0, 6) == 0)
					out_gap = $urandom_range(1, 14);
			end
		end
	end

	// input and output transactions, sampled at the rising edge
	always @(posedge clk) begin
		payload_beat_t want;
		logic [OUT_TDATA_W-1:0] want_data;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			absorb_rx_byte(s_axis_tdata);
			accepted++;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output: tdata=%h tlast=%b", m_axis_tdata, m_axis_tlast);
			end else begin
				want = expected_beats.pop_front();
				want_data = '0;
				want_data[7:0] = want.frame_type;
				want_data[15:8] = want.data_byte;
				want_data[19:16] = want.byte_index;
				want_data[24:20] = want.data_count;
				if (m_axis_tdata[7:0] !== want.frame_type ||
						m_axis_tdata[15:8] !== want.data_byte ||
						m_axis_tdata[19:16] !== want.byte_index ||
						m_axis_tdata[24:20] !== want.data_count ||
						m_axis_tdata[OUT_TDATA_W-1:25] !== '0 ||
						m_axis_tlast !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected tdata=%h tlast=%b, got tdata=%h tlast=%b",
							want_data, want.last, m_axis_tdata, m_axis_tlast);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic [7:0] body[$];
		int rand_octets;
		int rand_results;
		int total_items;
		int n;
		int pick;
		bit drain_mid_done;
		logic [7:0] b;

		// empty frame with type 0xff
		body = {};
		queue_frame(8'hFF, body, 1'b1, 1'b0);
		// wrong second sync byte; the second 0xaa must not restart a frame
		push_octet(SYNC_FIRST, 1'b0);
		push_octet(SYNC_FIRST, 1'b0);
		push_octet(SYNC_SECOND, 1'b0);
		push_octet(8'h03, 1'b0);
		push_octet(8'h00, 1'b0);
		push_octet(8'h00, 1'b0);
		// length too small, then too large
		push_octet(SYNC_FIRST, 1'b0);
		push_octet(SYNC_SECOND, 1'b0);
		push_octet(8'h02, 1'b0);
		push_octet(SYNC_FIRST, 1'b0);
		push_octet(SYNC_SECOND, 1'b0);
		push_octet(8'(DATA_MAX + 4), 1'b0);
		// bad checksum
		body = {8'h01, 8'h02};
		queue_frame(8'h00, body, 1'b0, 1'b0);
		// longest frame, extremes of the payload
		body = {8'h00, 8'hFF, 8'hAA, 8'h55};
		for (int i = 4; i < DATA_MAX; i++) body.push_back(8'($urandom_range(0, 255)));
		queue_frame(8'h00, body, 1'b1, 1'b0);

		// random part: mostly well-formed frames, some noise and broken headers
		rand_octets = 0;
		rand_results = 0;
		drain_mid_done = 1'b0;
		while (rand_octets < 45 || rand_results < 16) begin
			n = rx_bytes_pending.size();
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				body = {};
				if ($urandom_range(0, 9) < 7) pick = $urandom_range(0, 4);
				else pick = $urandom_range(0, DATA_MAX);
				for (int i = 0; i < pick; i++) body.push_back(8'($urandom_range(0, 255)));
				if ($urandom_range(0, 9) < 9) begin
					queue_frame(8'($urandom_range(0, 255)), body, 1'b1,
						rand_octets == 0 || (!drain_mid_done && rand_octets >= 22));
					rand_results += (pick == 0) ? 1 : pick;
					if (rand_octets >= 22) drain_mid_done = 1'b1;
				end else begin
					queue_frame(8'($urandom_range(0, 255)), body, 1'b0, rand_octets == 0);
				end
			end else if (pick < 88) begin
				// line noise that never looks like a first sync byte
				for (int i = $urandom_range(1, 4); i > 0; i--) begin
					b = 8'($urandom_range(0, 255));
					if (b == SYNC_FIRST) b = 8'h2A;
					push_octet(b, rand_octets == 0 && i == 1);
				end
			end else if (pick < 94) begin
				b = 8'($urandom_range(0, 255));
				if (b == SYNC_SECOND) b = 8'hD5;
				push_octet(SYNC_FIRST, rand_octets == 0);
				push_octet(b, 1'b0);
			end else begin
				if ($urandom_range(0, 1) == 0) b = 8'($urandom_range(0, 2));
				else b = 8'($urandom_range(DATA_MAX + 4, 255));
				push_octet(SYNC_FIRST, rand_octets == 0);
				push_octet(SYNC_SECOND, 1'b0);
				push_octet(b, 1'b0);
			end
			rand_octets += rx_bytes_pending.size() - n;
		end

		// tail with no idling on either side
		quiet_from = rx_bytes_pending.size();
		for (int f = 0; f < 3; f++) begin
			body = {};
			for (int i = $urandom_range(1, 5); i > 0; i--) body.push_back(8'($urandom_range(0, 255)));
			queue_frame(8'($urandom_range(0, 255)), body, 1'b1, 1'b0);
		end
		total_items = rx_bytes_pending.size();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (accepted < total_items) @(negedge clk);
		while (expected_beats.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0 && expected_beats.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
